// File: design/frw_pkg.sv
package frw_pkg;
  localparam int NodeDepth = 4096;
  localparam int MaxTrees = 64;
  localparam int NumFeatures = 64;
  localparam int MaxWalkSteps = 32;
  localparam int NodeAw = $clog2(NodeDepth);
  localparam int TreeAw = $clog2(MaxTrees);
  localparam int FeatAw = $clog2(NumFeatures);
  localparam int StepW = $clog2(MaxWalkSteps + 1);
  localparam int SumW = 32 + TreeAw + 1;
  localparam int CountW = 7;

  localparam logic [1:0] CMD_NODE = 2'd0;
  localparam logic [1:0] CMD_TREE = 2'd1;
  localparam logic [1:0] CMD_FEAT = 2'd2;
  localparam logic [1:0] CMD_RUN = 2'd3;

  localparam logic [1:0] ERR_OK = 2'd0;
  localparam logic [1:0] ERR_CHILD = 2'd1;
  localparam logic [1:0] ERR_STEPS = 2'd2;

  localparam int NodeW = 26 + 7 + 32 + 32 + 32;

  typedef struct packed {
    logic start;
    logic [CountW-1:0] divisor;
  } div_req_t;
endpackage

// File: design/frw_ram.sv
module frw_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input logic clk,
  input logic we,
  input logic [$clog2(Depth)-1:0] waddr,
  input logic [Width-1:0] wdata,
  input logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: design/frw_div.sv
// signed sum divided by small unsigned count, one quotient bit a cycle
module frw_div (
  input logic clk,
  input logic rst,
  input frw_pkg::div_req_t req,
  input logic [frw_pkg::SumW-1:0] dividend,
  output logic busy,
  output logic [31:0] quotient
);
  import frw_pkg::*;
  localparam int CntW = $clog2(SumW + 1);

  logic [SumW-1:0] quo;
  logic [CountW:0] rem;
  logic [CountW-1:0] dsr;
  logic neg;
  logic [CntW-1:0] cnt;
  logic [CountW:0] trial;
  logic [SumW-1:0] neg_quo;

  assign trial = {rem[CountW-1:0], quo[SumW-1]};
  assign neg_quo = -quo;
  assign quotient = neg ? neg_quo[31:0] : quo[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= CntW'(SumW);
      neg <= dividend[SumW-1];
      quo <= dividend[SumW-1] ? -dividend : dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dsr}) begin
        rem <= trial - {1'b0, dsr};
        quo <= {quo[SumW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[SumW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) busy <= 1'b0;
    end
  end
endmodule

// File: design/forest_regression_walk.sv
// one word at a time: in_stall is high from the accepting edge until the block is idle
// load words are written in the accepting cycle, then the block passes through S_WR to idle
// a run takes S_TREE for each tree and S_TWAIT, S_CHECK, S_NWAIT, S_NODE for each node read
// (tree entry, node and feature reads are registered), then two divides in turn, x and y,
// and then S_OUT, which holds the result longer while out_stall is high
// rst clears control state and the tree count to 1; stores are not cleared
module forest_regression_walk (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [6:0] cfg_wdata,
  input logic in_valid,
  output logic in_stall,
  input logic [1:0] command,
  input logic [5:0] tree_sel,
  input logic [11:0] node_address,
  input logic [12:0] tree_nodes,
  input logic signed [12:0] left_child,
  input logic signed [12:0] right_child,
  input logic signed [6:0] split_feature,
  input logic signed [31:0] threshold,
  input logic signed [31:0] leaf_x,
  input logic signed [31:0] leaf_y,
  input logic [5:0] feat_sel,
  input logic signed [31:0] feature_value,
  output logic out_valid,
  input logic out_stall,
  output logic signed [31:0] residual_x,
  output logic signed [31:0] residual_y,
  output logic [1:0] error_code
);
  import frw_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TREE = 4'd1;
  localparam logic [3:0] S_TWAIT = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_NWAIT = 4'd4;
  localparam logic [3:0] S_NODE = 4'd5;
  localparam logic [3:0] S_DIVX = 4'd6;
  localparam logic [3:0] S_DIVY = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;
  localparam logic [3:0] S_WR = 4'd9;
  localparam logic [3:0] S_DIVW = 4'd10;

  logic [3:0] state;
  logic [CountW-1:0] forest_size, n_eff;
  logic [TreeAw-1:0] tree;
  logic signed [13:0] idx;
  logic [StepW-1:0] steps;
  logic [SumW-1:0] sx, sy;
  logic [NodeAw-1:0] node_raddr;
  logic [NodeW-1:0] node_rd;
  logic [24:0] tree_rd;
  logic [31:0] feat_rd;
  logic [FeatAw-1:0] feat_raddr;
  logic feat_oob;
  logic [NodeAw:0] addr_full;
  logic accept;
  div_req_t dreq;
  logic [SumW-1:0] div_in;
  logic div_busy;
  logic [31:0] div_q;

  wire node_we = accept && command == CMD_NODE;
  wire tree_we = accept && command == CMD_TREE;
  wire feat_we = accept && command == CMD_FEAT;

  // node record: children, split, threshold, leaf x, leaf y
  wire signed [12:0] nd_left = node_rd[NodeW-1 -: 13];
  wire signed [12:0] nd_right = node_rd[NodeW-14 -: 13];
  wire signed [6:0] nd_split = node_rd[NodeW-27 -: 7];
  wire signed [31:0] nd_thr = node_rd[95:64];
  wire signed [31:0] nd_lx = node_rd[63:32];
  wire signed [31:0] nd_ly = node_rd[31:0];

  frw_ram #(.Width(NodeW), .Depth(NodeDepth)) u_nodes (
    .clk, .we(node_we), .waddr(node_address),
    .wdata({left_child, right_child, split_feature, threshold, leaf_x, leaf_y}),
    .raddr(node_raddr), .rdata(node_rd));

  frw_ram #(.Width(25), .Depth(MaxTrees)) u_trees (
    .clk, .we(tree_we), .waddr(tree_sel), .wdata({node_address, tree_nodes}),
    .raddr(tree), .rdata(tree_rd));

  frw_ram #(.Width(32), .Depth(NumFeatures)) u_feats (
    .clk, .we(feat_we), .waddr(feat_sel), .wdata(feature_value),
    .raddr(feat_raddr), .rdata(feat_rd));

  frw_div u_div (.clk, .rst, .req(dreq), .dividend(div_in), .busy(div_busy),
    .quotient(div_q));

  assign accept = in_valid && !in_stall;
  assign in_stall = state != S_IDLE;
  assign out_valid = state == S_OUT;
  assign n_eff = (forest_size == '0) ? CountW'(1) :
    (forest_size > CountW'(MaxTrees)) ? CountW'(MaxTrees) : forest_size;
  assign addr_full = {1'b0, tree_rd[24:13]} + (NodeAw+1)'(idx[12:0]);
  assign node_raddr = addr_full[NodeAw-1:0];
  assign feat_raddr = nd_split[FeatAw-1:0];
  assign feat_oob = $unsigned(nd_split) >= 7'(NumFeatures);
  assign div_in = (state == S_DIVX) ? sx : sy;

  // x divide starts from S_DIVX, y divide as soon as x is done
  always_comb begin
    dreq.divisor = n_eff;
    dreq.start = 1'b0;
    if ((state == S_DIVX || state == S_DIVY) && !div_busy) dreq.start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      forest_size <= CountW'(1);
    end else begin
      if (cfg_we) forest_size <= cfg_wdata;
      unique case (state)
        S_IDLE: if (accept) begin
          if (command == CMD_RUN) begin
            state <= S_TREE;
            tree <= '0;
            sx <= '0;
            sy <= '0;
          end else begin
            state <= S_WR;
          end
        end
        S_WR: state <= S_IDLE;
        S_TREE: begin
          idx <= '0;
          steps <= '0;
          state <= S_TWAIT;
        end
        S_TWAIT: state <= S_CHECK;
        S_CHECK: begin
          if (steps >= StepW'(MaxWalkSteps)) begin
            error_code <= ERR_STEPS;
            state <= S_OUT;
          end else if (idx < 0 || idx >= $signed({1'b0, tree_rd[12:0]}) ||
                       addr_full[NodeAw]) begin
            error_code <= ERR_CHILD;
            state <= S_OUT;
          end else begin
            steps <= steps + 1'b1;
            state <= S_NWAIT;
          end
          residual_x <= '0;
          residual_y <= '0;
        end
        S_NWAIT: state <= S_NODE;
        S_NODE: begin
          if (nd_split < 0) begin
            sx <= sx + SumW'(nd_lx);
            sy <= sy + SumW'(nd_ly);
            if (tree == TreeAw'(n_eff - 1'b1)) begin
              state <= S_DIVX;
            end else begin
              tree <= tree + 1'b1;
              state <= S_TREE;
            end
          end else begin
            idx <= ((feat_oob ? 32'sd0 : $signed(feat_rd)) <= nd_thr) ?
              14'(nd_left) : 14'(nd_right);
            state <= S_TWAIT;
          end
        end
        S_DIVX: if (dreq.start) state <= S_DIVY;
        S_DIVY: if (!div_busy) begin
          residual_x <= div_q;
          state <= S_DIVW;
        end
        S_DIVW: if (!div_busy) begin
          residual_y <= div_q;
          error_code <= ERR_OK;
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input taken while word waits");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code != ERR_OK) |-> (residual_x == 0))
    else $error("nonzero residual on error");
  assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> steps <= StepW'(MaxWalkSteps))
    else $error("step count overran");
endmodule

// File: test/tb_forest_regression_walk.sv
module tb_forest_regression_walk;
  import frw_pkg::*;

  localparam int CycleLimit = 20000000;
  localparam int SettleCycles = 60;
  localparam int PhaseCounts [6] = '{1, 0, 127, 64, 3, 5};

  typedef struct {
    logic [1:0] cmd;
    logic [5:0] tidx;
    logic [11:0] naddr;
    logic [12:0] tnodes;
    logic signed [12:0] lc;
    logic signed [12:0] rc;
    logic signed [6:0] sf;
    logic signed [31:0] thr;
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic [5:0] fidx;
    logic signed [31:0] fv;
  } word_t;

  typedef struct {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic [1:0] err;
  } residual_t;

  typedef struct {
    word_t w;
    bit typed;
    residual_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = CMD_NODE;
  logic [5:0] tree_sel = '0;
  logic [11:0] node_address = '0;
  logic [12:0] tree_nodes = '0;
  logic signed [12:0] left_child = '0;
  logic signed [12:0] right_child = '0;
  logic signed [6:0] split_feature = '0;
  logic signed [31:0] threshold = '0;
  logic signed [31:0] leaf_x = '0;
  logic signed [31:0] leaf_y = '0;
  logic [5:0] feat_sel = '0;
  logic signed [31:0] feature_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] residual_x;
  logic signed [31:0] residual_y;
  logic [1:0] error_code;

  // shadow copy of the forest stores
  logic signed [12:0] sh_left [NodeDepth];
  logic signed [12:0] sh_right [NodeDepth];
  logic signed [6:0] sh_split [NodeDepth];
  logic signed [31:0] sh_thr [NodeDepth];
  logic signed [31:0] sh_lx [NodeDepth];
  logic signed [31:0] sh_ly [NodeDepth];
  bit node_written [NodeDepth];
  int sh_base [MaxTrees];
  int sh_size [MaxTrees];
  logic signed [31:0] sh_feat [NumFeatures];
  int sh_count = 1;

  residual_t residual_q [$];
  int mismatches = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  row_t dir_tab [18];

  forest_regression_walk i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .tree_sel(tree_sel), .node_address(node_address), .tree_nodes(tree_nodes),
    .left_child(left_child), .right_child(right_child), .split_feature(split_feature),
    .threshold(threshold), .leaf_x(leaf_x), .leaf_y(leaf_y),
    .feat_sel(feat_sel), .feature_value(feature_value),
    .out_valid(out_valid), .out_stall(out_stall), .residual_x(residual_x),
    .residual_y(residual_y), .error_code(error_code)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_left <= 2000;
    end
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    residual_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
      if (out_valid && !out_stall) begin
        if (residual_q.size() == 0) begin
          report("unexpected word", {residual_x}, 32'h0);
        end else begin
          want = residual_q.pop_front();
          if (residual_x !== want.rx) report("residual_x", residual_x, want.rx);
          if (residual_y !== want.ry) report("residual_y", residual_y, want.ry);
          if (error_code !== want.err)
            report("error_code", 32'(error_code), 32'(want.err));
        end
      end
    end
  end

  function automatic word_t blank_word(logic [1:0] cmd);
    word_t w;
    w = '{cmd: cmd, default: '0};
    return w;
  endfunction

  function automatic word_t node_word(int a, int l, int r, int s, logic [31:0] t,
                                      logic [31:0] x, logic [31:0] y);
    word_t w;
    w = blank_word(CMD_NODE);
    w.naddr = 12'(a); w.lc = 13'(l); w.rc = 13'(r); w.sf = 7'(s);
    w.thr = t; w.lx = x; w.ly = y;
    return w;
  endfunction

  function automatic word_t tree_word(int t, int b, int n);
    word_t w;
    w = blank_word(CMD_TREE);
    w.tidx = 6'(t); w.naddr = 12'(b); w.tnodes = 13'(n);
    return w;
  endfunction

  function automatic word_t feat_word(int f, logic [31:0] v);
    word_t w;
    w = blank_word(CMD_FEAT);
    w.fidx = 6'(f); w.fv = v;
    return w;
  endfunction

  // walks the forest; returns a node address that is still unwritten, or -1
  function automatic int forest_mean(output residual_t r);
    int n, idx, steps, addr;
    bit done;
    longint sx, sy;
    logic [1:0] err;
    logic signed [31:0] fv;
    n = (sh_count < 1) ? 1 : ((sh_count > MaxTrees) ? MaxTrees : sh_count);
    sx = 0; sy = 0; err = ERR_OK;
    r = '{rx: '0, ry: '0, err: ERR_OK};
    for (int t = 0; t < n && err == ERR_OK; t++) begin
      idx = 0; steps = 0; done = 1'b0;
      while (!done) begin
        if (steps >= MaxWalkSteps) begin
          err = ERR_STEPS; done = 1'b1;
        end else begin
          steps++;
          if (idx < 0 || idx >= sh_size[t] || sh_base[t] + idx >= NodeDepth) begin
            err = ERR_CHILD; done = 1'b1;
          end else begin
            addr = sh_base[t] + idx;
            if (!node_written[addr]) return addr;
            if (sh_split[addr] < 0) begin
              sx += sh_lx[addr];
              sy += sh_ly[addr];
              done = 1'b1;
            end else begin
              fv = sh_feat[sh_split[addr]];
              idx = (fv <= sh_thr[addr]) ? int'(sh_left[addr]) : int'(sh_right[addr]);
            end
          end
        end
      end
    end
    r.err = err;
    if (err == ERR_OK) begin
      r.rx = 32'(sx / longint'(n));
      r.ry = 32'(sy / longint'(n));
    end
    return -1;
  endfunction

  function automatic void store_word(word_t w, bit predict);
    residual_t r;
    case (w.cmd)
      CMD_NODE: begin
        sh_left[w.naddr] = w.lc; sh_right[w.naddr] = w.rc;
        sh_split[w.naddr] = w.sf; sh_thr[w.naddr] = w.thr;
        sh_lx[w.naddr] = w.lx; sh_ly[w.naddr] = w.ly;
        node_written[w.naddr] = 1'b1;
      end
      CMD_TREE: begin
        sh_base[w.tidx] = int'(w.naddr); sh_size[w.tidx] = int'(w.tnodes);
      end
      CMD_FEAT: sh_feat[w.fidx] = w.fv;
      CMD_RUN: if (predict) begin
        void'(forest_mean(r));
        residual_q = {residual_q, r};
      end
    endcase
  endfunction

  // called at a rising edge; returns at the edge that accepted the word
  task automatic send(word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    command <= w.cmd; tree_sel <= w.tidx; node_address <= w.naddr;
    tree_nodes <= w.tnodes; left_child <= w.lc; right_child <= w.rc;
    split_feature <= w.sf; threshold <= w.thr; leaf_x <= w.lx; leaf_y <= w.ly;
    feat_sel <= w.fidx; feature_value <= w.fv;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (residual_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_tree_count(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= 7'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_count = v;
  endtask

  function automatic int rand_child();
    int k;
    k = $urandom_range(99);
    if (k < 70) return $urandom_range(7);
    if (k < 80) return -1;
    return $urandom_range(NodeDepth - 1);
  endfunction

  function automatic word_t rand_node(int a);
    bit leaf;
    logic [31:0] t;
    leaf = $urandom_range(99) < 40;
    t = ($urandom_range(1)) ? $urandom() : 32'(int'($urandom_range(0, 262143)) - 131072);
    return node_word(a, rand_child(), rand_child(), leaf ? -1 : $urandom_range(63),
                     t, $urandom(), $urandom());
  endfunction

  function automatic word_t rand_tree(int t);
    int k, b, n;
    k = $urandom_range(99);
    b = (k < 70) ? $urandom_range(56) : ((k < 90) ? $urandom_range(NodeDepth - 1)
                                                 : $urandom_range(4090, 4095));
    k = $urandom_range(99);
    n = (k < 60) ? $urandom_range(1, 8) : ((k < 80) ? $urandom_range(40)
                                                    : ((k < 90) ? 0 : $urandom_range(4096)));
    return tree_word(t, b, n);
  endfunction

  initial begin
    residual_t r;
    word_t w;
    int miss, k;

    dir_tab[0] = '{feat_word(0, 32'h7fffffff), 0, '{0, 0, ERR_OK}};
    dir_tab[1] = '{feat_word(63, 32'h80000000), 0, '{0, 0, ERR_OK}};
    // empty tree fails at the root
    dir_tab[2] = '{tree_word(0, 0, 0), 0, '{0, 0, ERR_OK}};
    dir_tab[3] = '{blank_word(CMD_RUN), 1, '{0, 0, ERR_CHILD}};
    dir_tab[4] = '{tree_word(0, 4095, 1), 0, '{0, 0, ERR_OK}};
    dir_tab[5] = '{node_word(4095, -1, -1, -1, 0, 32'h7fffffff, 32'h80000000), 0,
                   '{0, 0, ERR_OK}};
    dir_tab[6] = '{blank_word(CMD_RUN), 1, '{32'h7fffffff, 32'h80000000, ERR_OK}};
    // child address past the end of node memory
    dir_tab[7] = '{tree_word(0, 4095, 2), 0, '{0, 0, ERR_OK}};
    dir_tab[8] = '{node_word(4095, 1, -1, 0, 32'h7fffffff, 0, 0), 0, '{0, 0, ERR_OK}};
    dir_tab[9] = '{blank_word(CMD_RUN), 1, '{0, 0, ERR_CHILD}};
    // self loop runs into the step limit
    dir_tab[10] = '{node_word(4095, 0, 0, 63, 32'h80000000, 0, 0), 0, '{0, 0, ERR_OK}};
    dir_tab[11] = '{blank_word(CMD_RUN), 1, '{0, 0, ERR_STEPS}};
    dir_tab[12] = '{tree_word(0, 0, 4096), 0, '{0, 0, ERR_OK}};
    dir_tab[13] = '{node_word(0, 4095, 4095, -1, 0, -3, 5), 0, '{0, 0, ERR_OK}};
    dir_tab[14] = '{blank_word(CMD_RUN), 1, '{-3, 5, ERR_OK}};
    // negative child
    dir_tab[15] = '{node_word(0, 0, -1, 0, 0, 0, 0), 0, '{0, 0, ERR_OK}};
    dir_tab[16] = '{blank_word(CMD_RUN), 1, '{0, 0, ERR_CHILD}};
    dir_tab[17] = '{blank_word(CMD_RUN), 1, '{0, 0, ERR_CHILD}};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send(dir_tab[i].w);
      store_word(dir_tab[i].w, 1'b0);
      if (dir_tab[i].typed) residual_q = {residual_q, dir_tab[i].res};
    end

    for (int f = 0; f < NumFeatures; f++) begin
      w = feat_word(f, $urandom());
      send(w); store_word(w, 1'b0);
    end
    for (int t = 0; t < MaxTrees; t++) begin
      w = rand_tree(t);
      send(w); store_word(w, 1'b0);
    end

    for (int ph = 0; ph < 6; ph++) begin
      set_tree_count(ph == 5 ? $urandom_range(2, 8) : PhaseCounts[ph]);
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 72; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 72; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      hold_req = (ph == 0);
      for (int n = 0; n < 170; n++) begin
        if (n == 40) hold_req = 1'b0;
        k = $urandom_range(99);
        if (k < 25 || (ph == 0 && n < 40)) begin
          // write every node the walk reaches before the run itself
          miss = forest_mean(r);
          while (miss >= 0) begin
            w = rand_node(miss);
            send(w); store_word(w, 1'b0);
            miss = forest_mean(r);
          end
          w = blank_word(CMD_RUN);
        end else if (k < 65) begin
          w = rand_node($urandom_range(99) < 60 ? $urandom_range(63)
                                                : $urandom_range(NodeDepth - 1));
        end else if (k < 80) begin
          w = rand_tree($urandom_range(99) < 70 ? $urandom_range(7)
                                                : $urandom_range(MaxTrees - 1));
        end else begin
          w = feat_word($urandom_range(NumFeatures - 1), $urandom());
        end
        send(w);
        store_word(w, 1'b1);
      end
    end
    hold_req = 1'b0;
    set_tree_count(1);
    drain();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
design/frw_pkg.sv
design/frw_ram.sv
design/frw_div.sv
design/forest_regression_walk.sv
test/tb_forest_regression_walk.sv
